// ----- design/icm_pkg.sv -----
// Shared types, register codes and palette helpers for the color map core.
`default_nettype none
package icm_pkg;

    typedef logic [31:0] rgba_t;

    localparam logic [2:0] CFG_COLOR_MODE = 3'd0;
    localparam logic [2:0] CFG_MAX_ITER   = 3'd1;
    localparam logic [2:0] CFG_BAND_WIDTH = 3'd2;
    localparam logic [2:0] CFG_POINT_CNT  = 3'd3;
    localparam logic [2:0] CFG_COLORS_A   = 3'd4;
    localparam logic [2:0] CFG_COLORS_B   = 3'd5;
    localparam logic [2:0] CFG_COLORS_C   = 3'd6;

    localparam logic [1:0] MODE_STAMP    = 2'd0;
    localparam logic [1:0] MODE_GRADIENT = 2'd1;
    localparam logic [1:0] MODE_RAINBOW  = 2'd2;

    localparam logic [7:0] FULL_CHANNEL = 8'd255;
    localparam logic [15:0] BAND_RESET  = 16'd100;
    localparam logic [15:0] LIMIT_RESET = 16'd256;

    // Pick palette point k out of the three palette words.
    function automatic rgba_t palette_point(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] c, input logic [2:0] k);
        rgba_t p;
        case (k)
            3'd0: p = a[31:0];
            3'd1: p = a[63:32];
            3'd2: p = b[31:0];
            3'd3: p = b[63:32];
            3'd4: p = c[31:0];
            3'd5: p = c[63:32];
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- design/icm_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, lanes share a divisor.
`default_nettype none
module icm_div import icm_pkg::*; #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 16,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               ce,
    input  wire logic                               in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0]        in_num,
    input  wire logic [DEN_W-1:0]                   in_den,
    input  wire logic [SIDE_W-1:0]                  in_side,
    output logic                                    out_valid,
    output logic [LANES-1:0][NUM_W-1:0]             out_quot,
    output logic [LANES-1:0][DEN_W-1:0]             out_rem,
    output logic [SIDE_W-1:0]                       out_side
);

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic                           src_valid;
            logic [LANES-1:0][NUM_W-1:0]    src_work;
            logic [LANES-1:0][DEN_W-1:0]    src_rem;
            logic [DEN_W-1:0]               src_den;
            logic [SIDE_W-1:0]              src_side;

            logic                           valid_reg;
            logic [LANES-1:0][NUM_W-1:0]    work_reg;
            logic [LANES-1:0][DEN_W-1:0]    rem_reg;
            logic [DEN_W-1:0]               den_reg;
            logic [SIDE_W-1:0]              side_reg;

            logic [LANES-1:0][NUM_W-1:0]    work_next;
            logic [LANES-1:0][DEN_W-1:0]    rem_next;

            if (k == 0) begin : g_first
                assign src_valid = in_valid;
                assign src_work  = in_num;
                assign src_rem   = '0;
                assign src_den   = in_den;
                assign src_side  = in_side;
            end else begin : g_rest
                assign src_valid = g_stage[k-1].valid_reg;
                assign src_work  = g_stage[k-1].work_reg;
                assign src_rem   = g_stage[k-1].rem_reg;
                assign src_den   = g_stage[k-1].den_reg;
                assign src_side  = g_stage[k-1].side_reg;
            end

            always_comb begin
                logic [DEN_W:0] trial;
                logic           qbit;
                for (int l = 0; l < LANES; l++) begin
                    trial = {src_rem[l], src_work[l][NUM_W-1]};
                    qbit  = (trial >= {1'b0, src_den});
                    if (qbit) begin
                        rem_next[l] = DEN_W'(trial - {1'b0, src_den});
                    end else begin
                        rem_next[l] = trial[DEN_W-1:0];
                    end
                    work_next[l] = {src_work[l][NUM_W-2:0], qbit};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg <= 1'b0;
                end else if (ce) begin
                    valid_reg <= src_valid;
                end
                if (ce) begin
                    work_reg <= work_next;
                    rem_reg  <= rem_next;
                    den_reg  <= src_den;
                    side_reg <= src_side;
                end
            end
        end
    endgenerate

    assign out_valid = g_stage[NUM_W-1].valid_reg;
    assign out_quot  = g_stage[NUM_W-1].work_reg;
    assign out_rem   = g_stage[NUM_W-1].rem_reg;
    assign out_side  = g_stage[NUM_W-1].side_reg;

endmodule
`default_nettype wire

// ----- design/iteration_count_colormap_core.sv -----
// Iteration count to RGBA color map, top level.
// Path from input word to output word: capture stage, band divider, scale stage, segment divider,
// product and sum stages, channel divider and output register; the dividers give one quotient bit per stage.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset: synchronous active-low; clears valid bits and loads the register defaults.
`default_nettype none
module iteration_count_colormap_core import icm_pkg::*; #(
    parameter int MAX_POINTS = 6,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((COUNT_BITS+7)/8)*8-1:0]      s_tdata,  // iter_count
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [31:0]                               m_tdata,  // red, green, blue, alpha
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [2:0]                           cfg_index,
    input  wire logic [63:0]                          cfg_data
);

    localparam int CB   = COUNT_BITS;
    localparam int SW   = CB + 3;
    localparam int PW   = CB + 8;

    // configuration registers
    logic [1:0]    mode_reg;
    logic [CB-1:0] limit_reg;
    logic [CB-1:0] band_reg;
    logic [2:0]    count_reg;
    logic [63:0]   colors_a_reg, colors_b_reg, colors_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_GRADIENT;
            limit_reg    <= CB'(LIMIT_RESET);
            band_reg     <= CB'(BAND_RESET);
            count_reg    <= '0;
            colors_a_reg <= '0;
            colors_b_reg <= '0;
            colors_c_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COLOR_MODE: mode_reg     <= cfg_data[1:0];
                CFG_MAX_ITER:   limit_reg    <= cfg_data[CB-1:0];
                CFG_BAND_WIDTH: band_reg     <= cfg_data[CB-1:0];
                CFG_POINT_CNT:  count_reg    <= cfg_data[2:0];
                CFG_COLORS_A:   colors_a_reg <= cfg_data;
                CFG_COLORS_B:   colors_b_reg <= cfg_data;
                CFG_COLORS_C:   colors_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // derived configuration; the user must keep it stable while words are in flight, the block does not enforce it
    logic [2:0]    n_pts;
    logic [2:0]    pieces;
    logic [CB-1:0] band_eff;
    logic [CB-1:0] span;
    logic          rainbow;
    rgba_t         last_pt;

    assign n_pts    = (count_reg > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : count_reg;
    assign pieces   = n_pts - 3'd1;
    assign band_eff = (band_reg == '0) ? CB'(1) : band_reg;
    assign rainbow  = (mode_reg == MODE_RAINBOW);
    assign span     = rainbow ? band_eff : limit_reg;
    assign last_pt  = palette_point(colors_a_reg, colors_b_reg, colors_c_reg, pieces);

    logic ce;
    logic m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // stage 0: capture, settle fixed-color cases
    logic          fixed_next;
    rgba_t         color_next;
    logic [CB-1:0] iter_in;
    logic          s0_valid_reg;
    logic [CB-1:0] s0_iter_reg;
    logic          s0_fixed_reg;
    rgba_t         s0_color_reg;

    assign iter_in = s_tdata[CB-1:0];

    always_comb begin
        fixed_next = 1'b1;
        color_next = '0;
        if (mode_reg == MODE_STAMP) begin
            color_next = (iter_in == limit_reg) ? {FULL_CHANNEL, 24'd0}
                                                : {4{FULL_CHANNEL}};
        end else if (mode_reg != MODE_GRADIENT && !rainbow) begin
            color_next = '0;
        end else if (n_pts < 3'd2) begin
            color_next = '0;
        end else if (!rainbow && limit_reg == '0) begin
            color_next = last_pt;
        end else if (rainbow && iter_in == limit_reg) begin
            color_next = {FULL_CHANNEL, 24'd0};
        end else begin
            fixed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (ce) begin
            s0_valid_reg <= s_tvalid;
        end
        if (ce) begin
            s0_iter_reg  <= iter_in;
            s0_fixed_reg <= fixed_next;
            s0_color_reg <= color_next;
        end
    end

    // divider 1: iteration count modulo band width
    logic                    d1_valid;
    logic [0:0][CB-1:0]      d1_quot, d1_rem;
    logic [CB+32:0]          d1_side;

    icm_div #(.NUM_W(CB), .DEN_W(CB), .LANES(1), .SIDE_W(CB + 33)) u_div_band (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s0_valid_reg), .in_num(s0_iter_reg), .in_den(band_eff),
        .in_side({s0_fixed_reg, s0_color_reg, s0_iter_reg}),
        .out_valid(d1_valid), .out_quot(d1_quot), .out_rem(d1_rem), .out_side(d1_side)
    );

    // stage 1: scale position by piece count
    logic          s1_valid_reg;
    logic [SW-1:0] s1_scaled_reg;
    logic [32:0]   s1_side_reg;
    logic [CB-1:0] pos;

    assign pos = rainbow ? d1_rem[0] : d1_side[CB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= d1_valid;
        end
        if (ce) begin
            s1_scaled_reg <= SW'(pos) * SW'(pieces);
            s1_side_reg   <= d1_side[CB+32:CB];
        end
    end

    // divider 2: segment and remainder
    logic               d2_valid;
    logic [0:0][SW-1:0] d2_quot;
    logic [0:0][CB-1:0] d2_rem;
    logic [32:0]        d2_side;

    icm_div #(.NUM_W(SW), .DEN_W(CB), .LANES(1), .SIDE_W(33)) u_div_seg (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s1_valid_reg), .in_num(s1_scaled_reg), .in_den(span),
        .in_side(s1_side_reg),
        .out_valid(d2_valid), .out_quot(d2_quot), .out_rem(d2_rem), .out_side(d2_side)
    );

    // stage 2: channel products
    logic          seg_over;
    rgba_t         from_pt, to_pt;
    logic [CB-1:0] span_left;
    logic          s2_valid_reg;
    logic          s2_fixed_reg;
    rgba_t         s2_color_reg;
    logic [3:0][PW-1:0] s2_prod_a_reg, s2_prod_b_reg;

    assign seg_over  = (d2_quot[0] >= SW'(pieces));
    assign from_pt   = palette_point(colors_a_reg, colors_b_reg, colors_c_reg, d2_quot[0][2:0]);
    assign to_pt     = palette_point(colors_a_reg, colors_b_reg, colors_c_reg,
                                     d2_quot[0][2:0] + 3'd1);
    assign span_left = span - d2_rem[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (ce) begin
            s2_valid_reg <= d2_valid;
        end
        if (ce) begin
            s2_fixed_reg <= d2_side[32] || seg_over;
            s2_color_reg <= d2_side[32] ? d2_side[31:0] : last_pt;
            for (int ch = 0; ch < 4; ch++) begin
                s2_prod_a_reg[ch] <= PW'(from_pt[8*ch +: 8]) * PW'(span_left);
                s2_prod_b_reg[ch] <= PW'(to_pt[8*ch +: 8]) * PW'(d2_rem[0]);
            end
        end
    end

    // stage 3: blend sums
    logic               s3_valid_reg;
    logic [3:0][PW-1:0] s3_sum_reg;
    logic [32:0]        s3_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (ce) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (ce) begin
            for (int ch = 0; ch < 4; ch++) begin
                s3_sum_reg[ch] <= s2_prod_a_reg[ch] + s2_prod_b_reg[ch];
            end
            s3_side_reg <= {s2_fixed_reg, s2_color_reg};
        end
    end

    // divider 3: four channels over the span
    logic               d3_valid;
    logic [3:0][PW-1:0] d3_quot;
    logic [3:0][CB-1:0] d3_rem;
    logic [32:0]        d3_side;

    icm_div #(.NUM_W(PW), .DEN_W(CB), .LANES(4), .SIDE_W(33)) u_div_chan (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s3_valid_reg), .in_num(s3_sum_reg), .in_den(span),
        .in_side(s3_side_reg),
        .out_valid(d3_valid), .out_quot(d3_quot), .out_rem(d3_rem), .out_side(d3_side)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= d3_valid;
        end
        if (ce) begin
            m_tdata_reg <= d3_side[32] ? d3_side[31:0]
                         : {d3_quot[3][7:0], d3_quot[2][7:0], d3_quot[1][7:0], d3_quot[0][7:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the iteration count color map core.
`default_nettype none
module tb_top;
    import icm_pkg::*;

    localparam int WD_LIMIT = 20000;
    localparam int PIPE_DRAIN = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Shadow copy of the register file.
    logic [1:0]  sh_mode;
    logic [15:0] sh_limit;
    logic [15:0] sh_band;
    logic [2:0]  sh_points;
    logic [63:0] sh_pal [3];

    rgba_t pixel_q[$];
    int    mismatch_cnt = 0;
    int    idle_cycles = 0;
    bit    rx_hold;
    bit    hold_done;

    iteration_count_colormap_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic rgba_t pal_entry(input int k);
        logic [63:0] w;
        w = sh_pal[k / 2];
        return (k % 2) ? w[63:32] : w[31:0];
    endfunction

    function automatic rgba_t blend(input logic [31:0] pos, input logic [31:0] span,
                                    input int n);
        logic [31:0] scaled, seg, rem;
        logic [47:0] mix;
        rgba_t from_c, to_c, res;
        scaled = pos * (n - 1);
        seg = scaled / span;
        if (seg >= n - 1) return pal_entry(n - 1);
        rem = scaled - seg * span;
        from_c = pal_entry(seg);
        to_c = pal_entry(seg + 1);
        for (int ch = 0; ch < 4; ch++) begin
            mix = from_c[8*ch +: 8] * (span - rem) + to_c[8*ch +: 8] * rem;
            res[8*ch +: 8] = mix / span;
        end
        return res;
    endfunction

    function automatic rgba_t color_of(input logic [15:0] iter);
        int n;
        logic [31:0] band;
        n = (sh_points > 6) ? 6 : sh_points;
        if (sh_mode == MODE_STAMP)
            return (iter == sh_limit) ? {FULL_CHANNEL, 24'h0} : 32'hFFFF_FFFF;
        if (sh_mode == 2'd3 || n < 2) return '0;
        if (sh_mode == MODE_GRADIENT) begin
            if (sh_limit == 0) return pal_entry(n - 1);
            return blend(iter, sh_limit, n);
        end
        if (iter == sh_limit) return {FULL_CHANNEL, 24'h0};
        band = (sh_band == 0) ? 1 : sh_band;
        return blend(iter % band, band, n);
    endfunction

    // Burst-aware idle draw: 23 in 100, off during the quiet window.
    bit quiet;
    function automatic bit want_idle();
        return !quiet && ($urandom_range(99) < 23);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_COLOR_MODE: sh_mode   = val[1:0];
            CFG_MAX_ITER:   sh_limit  = val[15:0];
            CFG_BAND_WIDTH: sh_band   = val[15:0];
            CFG_POINT_CNT:  sh_points = val[2:0];
            CFG_COLORS_A:   sh_pal[0] = val;
            CFG_COLORS_B:   sh_pal[1] = val;
            CFG_COLORS_C:   sh_pal[2] = val;
            default: ;
        endcase
    endtask

    task automatic send_count(input logic [15:0] iter, input bit gaps);
        while (gaps && want_idle()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= iter;
        pixel_q = {pixel_q, color_of(iter)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic load_palette();
        write_reg(CFG_COLORS_A, {$urandom, $urandom});
        write_reg(CFG_COLORS_B, {$urandom, $urandom});
        write_reg(CFG_COLORS_C, {$urandom, $urandom});
    endtask

    task automatic test_directed();
        logic [15:0] edges [10];
        edges = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd255, 16'd256, 16'd257,
                  16'd32768, 16'hFFFE, 16'hFFFF};
        // Reset defaults: short palette gives zeros.
        send_count(16'd5, 1'b0);
        drain();
        write_reg(CFG_COLORS_A, 64'hFF00_FF00_00FF_00FF);
        write_reg(CFG_COLORS_B, 64'h1234_5678_80FF_0001);
        write_reg(CFG_COLORS_C, 64'hFFFF_FFFF_0000_0000);
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_COLOR_MODE, m);
            write_reg(CFG_POINT_CNT, (m == 3) ? 3'd7 : 3'd6);
            for (int i = 0; i < 5; i++) send_count(edges[i * 2 + (m % 2)], 1'b0);
            drain();
        end
        // Zero limit and zero band width.
        write_reg(CFG_MAX_ITER, 16'd0);
        write_reg(CFG_BAND_WIDTH, 16'd0);
        foreach (edges[i]) send_count(edges[i], 1'b0);
        drain();
        write_reg(CFG_COLOR_MODE, MODE_GRADIENT);
        send_count(16'd0, 1'b0);
        send_count(16'hFFFF, 1'b0);
        drain();
        write_reg(CFG_COLOR_MODE, MODE_STAMP);
        send_count(16'd0, 1'b0);
        drain();
    endtask

    task automatic pick_setting();
        int r;
        r = $urandom_range(9);
        write_reg(CFG_COLOR_MODE, (r == 0) ? 2'd3 : $urandom_range(2));
        case ($urandom_range(3))
            0: write_reg(CFG_MAX_ITER, $urandom_range(1, 16));
            1: write_reg(CFG_MAX_ITER, 16'hFFFF);
            2: write_reg(CFG_MAX_ITER, 16'd1);
            default: write_reg(CFG_MAX_ITER, $urandom);
        endcase
        write_reg(CFG_BAND_WIDTH, ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(1, 300));
        write_reg(CFG_POINT_CNT, $urandom_range(7));
        load_palette();
    endtask

    function automatic logic [15:0] rand_count();
        case ($urandom_range(3))
            0: return sh_limit + $urandom_range(2) - 1;
            1: return $urandom_range(2 * sh_band + 2);
            2: return $urandom_range(sh_limit + 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random();
        for (int phase = 0; phase < 12; phase++) begin
            pick_setting();
            quiet = (phase == 5);
            repeat (85) send_count(rand_count(), 1'b1);
            quiet = 1'b0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_COLOR_MODE, MODE_RAINBOW);
        write_reg(CFG_POINT_CNT, 3'd4);
        rx_hold = 1'b1;
        repeat (120) send_count(rand_count(), 1'b0);
        // Pause until every pixel is back before more traffic.
        drain();
        repeat (40) send_count(rand_count(), 1'b1);
        drain();
    endtask

    // Long receiver hold-off, counted here.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (rx_hold && !hold_done) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= !want_idle();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected pixel %h", m_tdata);
            end else begin
                rgba_t want;
                want = pixel_q.pop_front();
                for (int ch = 0; ch < 4; ch++)
                    if (want[8*ch +: 8] !== m_tdata[8*ch +: 8]) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("channel %0d: expected %h got %h", ch,
                                     want[8*ch +: 8], m_tdata[8*ch +: 8]);
                    end
            end
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        sh_mode = MODE_GRADIENT;
        sh_limit = LIMIT_RESET;
        sh_band = BAND_RESET;
        sh_points = '0;
        sh_pal = '{64'h0, 64'h0, 64'h0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

// ----- iteration_count_colormap_core.f -----
design/icm_pkg.sv
design/icm_div.sv
design/iteration_count_colormap_core.sv
bench/tb_top.sv
